// ===== rtl/meter_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Meter frame receiver assertion macros
// Shared concurrent assertion forms used by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef METER_FRAME_RECEIVER_DEFINES_SVH
`define METER_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Meter frame receiver package
// Types, codes and the CRC-16/ARC byte update shared by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfr_pkg;

    localparam int          CFG_IDX_W   = 2;
    localparam int          QUOT_W      = 51;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  MIN_SIZE    = 8'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PREAMBLE_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PREAMBLE_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET_SCOPE    = 2'd2;

    localparam logic [7:0]  PREAMBLE_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  PREAMBLE_SECOND_RST = 8'h55;
    localparam logic [15:0] TARGET_SCOPE_RST    = 16'h0B01;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_BAD  = 2'd1,
        ST_SIZE_BAD = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_ID    = 3'd2,
        PH_SIZE  = 3'd3,
        PH_SCOPE = 3'd4,
        PH_DATA  = 3'd5,
        PH_CRCLO = 3'd6,
        PH_CRCHI = 3'd7
    } t_phase;

    typedef struct packed {
        logic [7:0]  preamble_first;
        logic [7:0]  preamble_second;
        logic [15:0] target_scope;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic [39:0]        meter_id;
        logic [15:0]        scope_code;
        logic [7:0]         data_len;
        logic               is_target;
        logic [QUOT_W-1:0]  integer_part;
        logic [3:0]         tenths;
        logic               bad_digit;
        logic               value_overflow;
    } t_result;

    // CRC-16/ARC, reflected, one byte per call
    function automatic logic [15:0] mfr_crc16_arc_byte(input logic [15:0] crc_in,
                                                        input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/mfr_byte_if.sv =====
// ----------------------------------------------------------------------------
// Meter frame receiver byte channel
// Valid/ready channel carrying one received byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/mfr_result_if.sv =====
// ----------------------------------------------------------------------------
// Meter frame receiver result channel
// Valid/ready channel carrying one decoded frame report per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [39:0] meter_id;
    logic [15:0] scope_code;
    logic [7:0]  data_len;
    logic        is_target;
    logic [50:0] integer_part;
    logic [3:0]  tenths;
    logic        bad_digit;
    logic        value_overflow;

    modport source (
        output valid, output status, output meter_id, output scope_code,
        output data_len, output is_target, output integer_part, output tenths,
        output bad_digit, output value_overflow,
        input  ready
    );
    modport sink (
        input  valid, input status, input meter_id, input scope_code,
        input  data_len, input is_target, input integer_part, input tenths,
        input  bad_digit, input value_overflow,
        output ready
    );
endinterface

// ===== rtl/mfr_parser.sv =====
// ----------------------------------------------------------------------------
// Meter frame parser
// Frame state machine: preamble hunt, field capture, CRC and BCD decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_parser #(
    parameter int ID_BYTES        = 5,
    parameter int MAX_VALUE_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    input  mfr_pkg::t_cfg    i_cfg,
    output logic             o_hit,
    output mfr_pkg::t_result o_result
);
    import mfr_pkg::*;

    localparam int ID_W = ID_BYTES * 8;

    t_phase            r_phase,        n_phase;
    logic [7:0]        r_byte_count,   n_byte_count;
    logic [15:0]       r_crc,          n_crc;
    logic [ID_W-1:0]   r_id_shift,     n_id_shift;
    logic [7:0]        r_payload_left, n_payload_left;
    logic [15:0]       r_scope,        n_scope;
    logic [QUOT_W-1:0] r_quot,         n_quot;
    logic [3:0]        r_rem,          n_rem;
    logic [7:0]        r_crc_low,      n_crc_low;
    logic              r_digit_error,  n_digit_error;
    logic              r_too_long,     n_too_long;

    logic [3:0]        hi, lo;
    logic [15:0]       crc_next;
    logic [63:0]       id_wide;
    logic              crc_good, target, keep_value;
    logic [7:0]        small_add;
    logic [QUOT_W-1:0] quot_x100;
    logic              clear;
    logic [7:0]        size_left;

    assign hi         = i_byte[7:4];
    assign lo         = i_byte[3:0];
    assign crc_next   = mfr_crc16_arc_byte(r_crc, i_byte);
    assign id_wide    = 64'(r_id_shift);
    assign crc_good   = ({i_byte, r_crc_low} == r_crc);
    assign target     = crc_good && (r_scope == i_cfg.target_scope);
    assign keep_value = target && !r_too_long;
    assign size_left  = i_byte - MIN_SIZE;

    // value = 10*q + r; value*100 + d gives q' = 100q + 10r + d/10, r' = d mod 10
    assign quot_x100  = (r_quot << 6) + (r_quot << 5) + (r_quot << 2);
    assign small_add  = 8'(r_rem) * 8'd10 + 8'(hi) + 8'(lo > 4'd9);

    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_crc          = r_crc;
        n_id_shift     = r_id_shift;
        n_payload_left = r_payload_left;
        n_scope        = r_scope;
        n_quot         = r_quot;
        n_rem          = r_rem;
        n_crc_low      = r_crc_low;
        n_digit_error  = r_digit_error;
        n_too_long     = r_too_long;
        clear          = 1'b0;
        o_hit          = 1'b0;

        o_result.status         = crc_good ? ST_GOOD : ST_CRC_BAD;
        o_result.meter_id       = id_wide[39:0];
        o_result.scope_code     = r_scope;
        o_result.data_len       = r_byte_count;
        o_result.is_target      = target;
        o_result.integer_part   = keep_value ? r_quot : '0;
        o_result.tenths         = keep_value ? r_rem : 4'd0;
        o_result.bad_digit      = r_digit_error;
        o_result.value_overflow = r_too_long;

        case (r_phase)
            PH_HUNT1: begin
                if (i_byte == i_cfg.preamble_first) begin
                    n_phase = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                // a mismatching byte is dropped, not retried as a first byte
                if (i_byte == i_cfg.preamble_second) begin
                    clear = 1'b1;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_ID: begin
                n_crc        = crc_next;
                n_id_shift   = ID_W'({r_id_shift, i_byte});
                n_byte_count = r_byte_count + 8'd1;
                if (n_byte_count >= 8'(ID_BYTES)) begin
                    n_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                if (i_byte < MIN_SIZE) begin
                    o_hit                   = 1'b1;
                    o_result.status         = ST_SIZE_BAD;
                    o_result.scope_code     = '0;
                    o_result.data_len       = '0;
                    o_result.is_target      = 1'b0;
                    o_result.integer_part   = '0;
                    o_result.tenths         = '0;
                    o_result.bad_digit      = 1'b0;
                    o_result.value_overflow = 1'b0;
                    clear                   = 1'b1;
                end else begin
                    n_crc          = crc_next;
                    n_payload_left = size_left;
                    n_too_long     = size_left > 8'(MAX_VALUE_BYTES);
                    n_byte_count   = '0;
                    n_phase        = PH_SCOPE;
                end
            end
            PH_SCOPE: begin
                n_crc        = crc_next;
                n_scope      = {r_scope[7:0], i_byte};
                n_byte_count = r_byte_count + 8'd1;
                if (r_byte_count != 8'd0) begin
                    n_byte_count = '0;
                    n_phase      = (r_payload_left == 8'd0) ? PH_CRCLO : PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc = crc_next;
                if (hi > 4'd9 || lo > 4'd9) begin
                    n_digit_error = 1'b1;
                end
                if (r_byte_count < 8'(MAX_VALUE_BYTES)) begin
                    n_quot = quot_x100 + QUOT_W'(small_add);
                    n_rem  = (lo > 4'd9) ? (lo - 4'd10) : lo;
                end
                n_byte_count   = r_byte_count + 8'd1;
                n_payload_left = r_payload_left - 8'd1;
                if (r_payload_left == 8'd1) begin
                    n_phase = PH_CRCLO;
                end
            end
            PH_CRCLO: begin
                n_crc_low = i_byte;
                n_phase   = PH_CRCHI;
            end
            PH_CRCHI: begin
                o_hit = 1'b1;
                clear = 1'b1;
            end
            default: begin
                clear = 1'b1;
            end
        endcase

        if (clear) begin
            n_byte_count   = '0;
            n_crc          = '0;
            n_id_shift     = '0;
            n_payload_left = '0;
            n_scope        = '0;
            n_quot         = '0;
            n_rem          = '0;
            n_crc_low      = '0;
            n_digit_error  = 1'b0;
            n_too_long     = 1'b0;
            n_phase        = (r_phase == PH_HUNT2) ? PH_ID : PH_HUNT1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT1;
            r_byte_count   <= '0;
            r_crc          <= '0;
            r_id_shift     <= '0;
            r_payload_left <= '0;
            r_scope        <= '0;
            r_quot         <= '0;
            r_rem          <= '0;
            r_crc_low      <= '0;
            r_digit_error  <= 1'b0;
            r_too_long     <= 1'b0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_crc          <= n_crc;
            r_id_shift     <= n_id_shift;
            r_payload_left <= n_payload_left;
            r_scope        <= n_scope;
            r_quot         <= n_quot;
            r_rem          <= n_rem;
            r_crc_low      <= n_crc_low;
            r_digit_error  <= n_digit_error;
            r_too_long     <= n_too_long;
        end
    end

endmodule

// ===== rtl/meter_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Meter frame receiver
// Takes one serial byte per word, hunts for a two-byte preamble, reads
// identifier, size, scope, packed BCD data and a little-endian CRC-16/ARC,
// and reports one word per frame on the last CRC byte (or at once on a size
// byte below two). A byte is taken every cycle: it lands in an input
// register, the frame state machine consumes it from there and a report
// goes to an output register, from which it is offered on the report
// channel. The only stall is a byte that ends a frame while the
// previous report is still waiting in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "meter_frame_receiver_defines.svh"

module meter_frame_receiver #(
    parameter int ID_BYTES        = 5,
    parameter int MAX_VALUE_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mfr_byte_if.sink                       i_rx,
    mfr_result_if.source                   o_res,
    input  logic                           i_cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import mfr_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       hit;
    logic       advance;
    t_result    result;

    // hold the byte when it would finish a frame into a full output register
    assign advance    = r_in_valid && (!hit || !r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    mfr_parser #(
        .ID_BYTES        (ID_BYTES),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_cfg     (r_cfg),
        .o_hit     (hit),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_first  <= PREAMBLE_FIRST_RST;
            r_cfg.preamble_second <= PREAMBLE_SECOND_RST;
            r_cfg.target_scope    <= TARGET_SCOPE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_PREAMBLE_FIRST:  r_cfg.preamble_first  <= i_cfg_data[7:0];
                CFG_IDX_PREAMBLE_SECOND: r_cfg.preamble_second <= i_cfg_data[7:0];
                CFG_IDX_TARGET_SCOPE:    r_cfg.target_scope    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && hit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && hit) begin
            r_out <= result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out.status;
    assign o_res.meter_id       = r_out.meter_id;
    assign o_res.scope_code     = r_out.scope_code;
    assign o_res.data_len       = r_out.data_len;
    assign o_res.is_target      = r_out.is_target;
    assign o_res.integer_part   = r_out.integer_part;
    assign o_res.tenths         = r_out.tenths;
    assign o_res.bad_digit      = r_out.bad_digit;
    assign o_res.value_overflow = r_out.value_overflow;

    `MFR_ASSERT_IMPLY(a_tenths_digit, i_clk, i_rst_n, r_out_valid, r_out.tenths <= 4'd9, "tenths above nine")
    `MFR_ASSERT_IMPLY(a_target_good, i_clk, i_rst_n, r_out_valid && r_out.is_target, r_out.status == ST_GOOD, "target on bad frame")
    `MFR_ASSERT_IMPLY(a_value_gated, i_clk, i_rst_n, r_out_valid && !r_out.is_target, r_out.integer_part == '0 && r_out.tenths == 4'd0, "value on non-target frame")
    `MFR_ASSERT_IMPLY(a_size_err_empty, i_clk, i_rst_n, r_out_valid && r_out.status == ST_SIZE_BAD, r_out.scope_code == 16'd0 && r_out.data_len == 8'd0, "size error with fields")
    `MFR_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in_byte), "held byte lost")

endmodule

// ===== dv/mfr_frame_checker.sv =====
// ----------------------------------------------------------------------------
// Meter frame receiver checker
// Watches the byte and report channels and the register write port, keeps
// its own copy of the frame parser state, and compares each report word
// against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_frame_checker #(
    parameter int ID_BYTES        = 5,
    parameter int MAX_VALUE_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mfr_byte_if                           i_rx,
    mfr_result_if                         i_res,
    input  logic                          i_cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_good_count,
    output int                            o_target_count,
    output int                            o_crc_bad_count,
    output int                            o_size_bad_count
);
    import mfr_pkg::*;

    // register copies
    logic [7:0]  pre_first;
    logic [7:0]  pre_second;
    logic [15:0] scope_of_interest;

    // parser state
    t_phase      frame_phase;
    logic [7:0]  field_count;
    logic [15:0] crc_acc;
    logic [39:0] id_acc;
    logic [7:0]  data_left;
    logic [15:0] scope_acc;
    logic [53:0] bcd_acc;
    logic [7:0]  crc_low;
    logic        digit_bad;
    logic        data_overflow;

    t_result     predicted_reports[$];

    int fail_total     = 0;
    int good_total     = 0;
    int target_total   = 0;
    int crc_bad_total  = 0;
    int size_bad_total = 0;

    // CRC-16/ARC, one data bit at a time, LSB first
    function automatic logic [15:0] crc_next(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c ^= CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void restart_hunt();
        frame_phase   = PH_HUNT1;
        field_count   = '0;
        crc_acc       = '0;
        id_acc        = '0;
        data_left     = '0;
        scope_acc     = '0;
        bcd_acc       = '0;
        crc_low       = '0;
        digit_bad     = 1'b0;
        data_overflow = 1'b0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        t_result     rpt;
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic [15:0] rx_crc;
        logic [63:0] value;
        rpt = '0;
        hi  = b[7:4];
        lo  = b[3:0];
        case (frame_phase)
            PH_HUNT1: begin
                if (b == pre_first) frame_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                // a wrong second byte is dropped, not retried as a first byte
                if (b == pre_second) begin
                    restart_hunt();
                    frame_phase = PH_ID;
                end else begin
                    frame_phase = PH_HUNT1;
                end
            end
            PH_ID: begin
                crc_acc = crc_next(crc_acc, b);
                id_acc  = {id_acc[31:0], b};
                field_count++;
                if (field_count >= ID_BYTES) frame_phase = PH_SIZE;
            end
            PH_SIZE: begin
                if (b < MIN_SIZE) begin
                    rpt.status   = ST_SIZE_BAD;
                    rpt.meter_id = id_acc;
                    predicted_reports.push_back(rpt);
                    restart_hunt();
                end else begin
                    crc_acc       = crc_next(crc_acc, b);
                    data_left     = b - MIN_SIZE;
                    data_overflow = data_left > MAX_VALUE_BYTES;
                    field_count   = '0;
                    frame_phase   = PH_SCOPE;
                end
            end
            PH_SCOPE: begin
                crc_acc   = crc_next(crc_acc, b);
                scope_acc = {scope_acc[7:0], b};
                field_count++;
                if (field_count >= 2) begin
                    field_count = '0;
                    frame_phase = (data_left == 0) ? PH_CRCLO : PH_DATA;
                end
            end
            PH_DATA: begin
                crc_acc = crc_next(crc_acc, b);
                if (hi > 9 || lo > 9) digit_bad = 1'b1;
                // out-of-range nibbles still weigh in as given
                if (field_count < MAX_VALUE_BYTES) begin
                    bcd_acc = 54'(64'(bcd_acc) * 100 + hi * 10 + lo);
                end
                field_count++;
                data_left--;
                if (data_left == 0) frame_phase = PH_CRCLO;
            end
            PH_CRCLO: begin
                crc_low     = b;
                frame_phase = PH_CRCHI;
            end
            default: begin
                rx_crc             = {b, crc_low};
                rpt.status         = (rx_crc == crc_acc) ? ST_GOOD : ST_CRC_BAD;
                rpt.meter_id       = id_acc;
                rpt.scope_code     = scope_acc;
                rpt.data_len       = field_count;
                rpt.is_target      = (rx_crc == crc_acc) && (scope_acc == scope_of_interest);
                value              = (rpt.is_target && !data_overflow) ? 64'(bcd_acc) : 64'd0;
                rpt.integer_part   = QUOT_W'(value / 10);
                rpt.tenths         = 4'(value % 10);
                rpt.bad_digit      = digit_bad;
                rpt.value_overflow = data_overflow;
                predicted_reports.push_back(rpt);
                restart_hunt();
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endfunction

    function automatic void check_report();
        t_result want;
        if (predicted_reports.size() == 0) begin
            $error("report word with no frame pending: status %0d id 0x%0h",
                   i_res.status, i_res.meter_id);
            fail_total++;
        end else begin
            want = predicted_reports.pop_front();
            check_field("status",         want.status,         i_res.status);
            check_field("meter_id",       want.meter_id,       i_res.meter_id);
            check_field("scope_code",     want.scope_code,     i_res.scope_code);
            check_field("data_len",       want.data_len,       i_res.data_len);
            check_field("is_target",      want.is_target,      i_res.is_target);
            check_field("integer_part",   want.integer_part,   i_res.integer_part);
            check_field("tenths",         want.tenths,         i_res.tenths);
            check_field("bad_digit",      want.bad_digit,      i_res.bad_digit);
            check_field("value_overflow", want.value_overflow, i_res.value_overflow);
            case (want.status)
                ST_GOOD:     good_total++;
                ST_CRC_BAD:  crc_bad_total++;
                default:     size_bad_total++;
            endcase
            if (want.is_target) target_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pre_first         = PREAMBLE_FIRST_RST;
            pre_second        = PREAMBLE_SECOND_RST;
            scope_of_interest = TARGET_SCOPE_RST;
            restart_hunt();
            predicted_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_PREAMBLE_FIRST:  pre_first         = i_cfg_data[7:0];
                    CFG_IDX_PREAMBLE_SECOND: pre_second        = i_cfg_data[7:0];
                    CFG_IDX_TARGET_SCOPE:    scope_of_interest = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx.valid && i_rx.ready) parse_byte(i_rx.rx_byte);
            if (i_res.valid && i_res.ready) check_report();
        end
        o_pending        <= predicted_reports.size();
        o_fail_count     <= fail_total;
        o_good_count     <= good_total;
        o_target_count   <= target_total;
        o_crc_bad_count  <= crc_bad_total;
        o_size_bad_count <= size_bad_total;
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Meter frame receiver testbench
// Feeds short directed frames and then random frame streams (good frames,
// CRC errors, short sizes, bad BCD digits, overlong data, noise and cut
// frames) under several register settings and idle mixes; the checker
// predicts and compares every report word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import mfr_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int SETTLE_CYCLES     = 8;
    localparam int BYTES_PER_SETTING = 330;
    localparam int NUM_SETTINGS      = 6;

    typedef logic [7:0] t_byte_q[$];

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    int fail_count;
    int pending;
    int good_count;
    int target_count;
    int crc_bad_count;
    int size_bad_count;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int bytes_sent   = 0;
    int idle_cycles  = 0;

    logic [7:0]  cur_first;
    logic [7:0]  cur_second;
    logic [15:0] cur_target;

    mfr_byte_if   rx_chan ();
    mfr_result_if report_chan ();

    meter_frame_receiver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_chan),
        .o_res       (report_chan),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mfr_frame_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx             (rx_chan),
        .i_res            (report_chan),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_good_count     (good_count),
        .o_target_count   (target_count),
        .o_crc_bad_count  (crc_bad_count),
        .o_size_bad_count (size_bad_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        report_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // end the run if no word moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_chan.valid && rx_chan.ready) ||
            (report_chan.valid && report_chan.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold valid across back-to-back words; drop it only for idle cycles
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            rx_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_chan.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic push_bytes(input t_byte_q q, input int count);
        for (int k = 0; k < count; k++) push_byte(q[k]);
    endtask

    // stop sending and wait until every predicted report has come out
    task automatic drain();
        rx_chan.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [7:0] first_b, input logic [7:0] second_b,
                                  input logic [15:0] scope);
        cur_first  = first_b;
        cur_second = second_b;
        cur_target = scope;
        cfg_write(CFG_IDX_PREAMBLE_FIRST, {8'h00, first_b});
        cfg_write(CFG_IDX_PREAMBLE_SECOND, {8'h00, second_b});
        cfg_write(CFG_IDX_TARGET_SCOPE, scope);
        cfg_we <= 1'b0;
    endtask

    function automatic void build_frame(input logic [39:0] id, input logic [7:0] size,
                                        input logic [15:0] scope, input t_byte_q data,
                                        input logic [15:0] crc_flip, output t_byte_q frame);
        logic [15:0] crc;
        t_byte_q     body;
        body.delete();
        for (int k = 4; k >= 0; k--) body.push_back(id[8*k +: 8]);
        body.push_back(size);
        if (size >= MIN_SIZE) begin
            body.push_back(scope[15:8]);
            body.push_back(scope[7:0]);
            foreach (data[k]) body.push_back(data[k]);
        end
        crc = 16'h0000;
        foreach (body[k]) crc = mfr_crc16_arc_byte(crc, body[k]);
        crc ^= crc_flip;
        frame.delete();
        frame.push_back(cur_first);
        frame.push_back(cur_second);
        foreach (body[k]) frame.push_back(body[k]);
        if (size >= MIN_SIZE) begin
            frame.push_back(crc[7:0]);
            frame.push_back(crc[15:8]);
        end
    endfunction

    // forced_size < 0 picks the size at random
    task automatic random_frame(input int forced_size);
        logic [39:0] id;
        logic [7:0]  size;
        logic [15:0] scope;
        logic [15:0] flip;
        t_byte_q     data;
        t_byte_q     frame;
        int          pick;
        int          cut;

        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        end else if (pick < 20) begin
            // broken preamble
            push_byte(cur_first);
            push_byte(8'($urandom));
        end

        pick = $urandom_range(9);
        id = (pick == 0) ? 40'h0 : (pick == 1) ? {40{1'b1}} : {$urandom, 8'($urandom)};

        if (forced_size >= 0) begin
            size = 8'(forced_size);
        end else begin
            pick = $urandom_range(99);
            if (pick < 5)      size = 8'($urandom_range(1));
            else if (pick < 8) size = 8'($urandom_range(13, 60));
            else if (pick < 9) size = 8'hFF;
            else               size = 8'($urandom_range(2, 12));
        end

        pick = $urandom_range(99);
        if (pick < 50)      scope = cur_target;
        else if (pick < 60) scope = cur_target ^ (16'h1 << $urandom_range(15));
        else                scope = 16'($urandom);

        data.delete();
        for (int k = 2; k < size; k++) begin
            pick = $urandom_range(99);
            if (pick < 10)      data.push_back(8'($urandom));
            else if (pick < 15) data.push_back(8'h99);
            else if (pick < 20) data.push_back(8'h00);
            else data.push_back({4'($urandom_range(9)), 4'($urandom_range(9))});
        end

        flip = ($urandom_range(99) < 15) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        build_frame(id, size, scope, data, flip, frame);

        cut = frame.size();
        if ($urandom_range(99) < 4) cut = $urandom_range(1, frame.size() - 1);
        push_bytes(frame, cut);
    endtask

    initial begin
        t_byte_q frame;
        t_byte_q no_data;
        int      start;

        i_rst_n           <= 1'b0;
        rx_chan.valid     <= 1'b0;
        rx_chan.rx_byte   <= 8'h00;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_IDX_PREAMBLE_FIRST;
        cfg_data          <= 16'h0000;
        cur_first         = PREAMBLE_FIRST_RST;
        cur_second        = PREAMBLE_SECOND_RST;
        cur_target        = TARGET_SCOPE_RST;
        no_data.delete();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s < 2) begin
                tx_idle_pct  = 10;
                rx_stall_pct = 69;
            end else if (s < 4) begin
                tx_idle_pct  = 69;
                rx_stall_pct = 10;
            end else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end

            if (s == 0) begin
                // second preamble mismatch, then a size byte of zero with an
                // all-ones id, then a good target frame with no data
                push_byte(cur_first);
                push_byte(cur_first);
                push_byte(cur_second);
                build_frame({40{1'b1}}, 8'h00, 16'h0000, no_data, 16'h0000, frame);
                push_bytes(frame, frame.size());
                build_frame(40'h0, MIN_SIZE, cur_target, no_data, 16'h0000, frame);
                push_bytes(frame, frame.size());
            end else begin
                drain();
                case (s)
                    1: apply_settings(8'h00, 8'hFF, 16'h0000);
                    2: apply_settings(8'hFF, 8'h00, 16'hFFFF);
                    3: apply_settings(8'($urandom), 8'($urandom), 16'($urandom));
                    4: begin
                        // same byte for both preamble positions
                        start = $urandom_range(255);
                        apply_settings(8'(start), 8'(start), 16'($urandom));
                    end
                    default: apply_settings(PREAMBLE_FIRST_RST, PREAMBLE_SECOND_RST,
                                            TARGET_SCOPE_RST);
                endcase
            end

            start = bytes_sent;
            if (s == 3) random_frame(255);
            while (bytes_sent - start < BYTES_PER_SETTING) random_frame(-1);
        end

        drain();
        $display("covered %0d bytes under %0d register settings and three idle mixes",
                 bytes_sent, NUM_SETTINGS);
        $display("reports: %0d good (%0d target values), %0d CRC errors, %0d short sizes",
                 good_count, target_count, crc_bad_count, size_bad_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
